>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the rtl, emptied when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif

`endif

>>> rtl/modexp_pkg.sv
// ----------------------------------------------------------------------------
// modexp_pkg
// widths and word types of the modular exponentiation block
// ----------------------------------------------------------------------------
package modexp_pkg;

   // operand width of base, exponent, modulus and result
   localparam int OPERAND_BITS = 31;

   // value returned for a zero exponent
   localparam logic [OPERAND_BITS-1:0] ONE_VALUE = {{(OPERAND_BITS-1){1'b0}}, 1'b1};

   // request word
   typedef struct packed {
      logic [OPERAND_BITS-1:0] base_value;
      logic [OPERAND_BITS-1:0] exponent_value;
      logic [OPERAND_BITS-1:0] modulus_value;
   } req_payload_type;

   // response word
   typedef struct packed {
      logic [OPERAND_BITS-1:0] power_result;
   } rsp_payload_type;

endpackage

>>> rtl/modexp_ifs.sv
// ----------------------------------------------------------------------------
// modexp channel interfaces
// valid/ready channels carrying request and response words
// ----------------------------------------------------------------------------
interface modexp_req_if import modexp_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface modexp_rsp_if import modexp_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/modular_exponentiation_top.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_top
// operation: a zero exponent or zero modulus goes straight to the hold state,
//   otherwise the sequencer runs a base reduction, then squarings and multiplies;
//   the finished response word waits in hold until the response register is free
// throughput: one word at a time; each modular multiply is a bit-serial
//   interleaved radix-2 unit
// reset: synchronous, clears the sequencer and the response valid
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module modular_exponentiation_top import modexp_pkg::*; (
   input logic            clock,
   input logic            reset,
   modexp_req_if.sink     req_ch,
   modexp_rsp_if.source   rsp_ch
);

   localparam int W        = OPERAND_BITS;
   localparam int CNT_BITS = $clog2(OPERAND_BITS);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(OPERAND_BITS - 1);

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   // multiply operations
   localparam logic [1:0] OP_RED = 2'd0;  // base reduced by the modulus
   localparam logic [1:0] OP_MUL = 2'd1;  // accumulator times running base
   localparam logic [1:0] OP_SQR = 2'd2;  // running base squared

   logic [1:0]          state_ff, state_in;
   logic [1:0]          op_ff, op_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [W-1:0]        mod_ff, mod_in;
   logic [W-1:0]        exp_ff, exp_in;
   logic [W-1:0]        acc_ff, acc_in;
   logic [W-1:0]        run_ff, run_in;
   logic [W-1:0]        x_ff, x_in;
   logic [W-1:0]        y_ff, y_in;
   logic [W-1:0]        r_ff, r_in;
   logic [W-1:0]        out_ff, out_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [W+1:0]        step_sum;
   logic [W+1:0]        mod_one;
   logic [W+1:0]        mod_two;
   logic [W+1:0]        step_red;
   logic [W-1:0]        prod;

   // one radix-2 step: partial result doubled plus multiplicand when the multiplier top bit is set, below three moduli
   assign mod_one  = {2'b00, mod_ff};
   assign mod_two  = {1'b0, mod_ff, 1'b0};
   assign step_sum = {1'b0, r_ff, 1'b0} + (x_ff[W-1] ? {2'b00, y_ff} : '0);

   always_comb begin
      if (step_sum >= mod_two) begin
         step_red = step_sum - mod_two;
      end else if (step_sum >= mod_one) begin
         step_red = step_sum - mod_one;
      end else begin
         step_red = step_sum;
      end
   end

   assign prod = step_red[W-1:0];

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      cnt_in       = cnt_ff;
      mod_in       = mod_ff;
      exp_in       = exp_ff;
      acc_in       = acc_ff;
      run_in       = run_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      r_in         = r_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff;

      // response word taken
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               mod_in = req_ch.payload.modulus_value;
               exp_in = req_ch.payload.exponent_value;
               x_in   = req_ch.payload.base_value;
               y_in   = ONE_VALUE;
               r_in   = '0;
               cnt_in = '0;
               op_in  = OP_RED;
               // zero exponent gives one; zero modulus gives zero
               if (req_ch.payload.exponent_value == '0) begin
                  acc_in   = ONE_VALUE;
                  state_in = ST_HOLD;
               end else if (req_ch.payload.modulus_value == '0) begin
                  acc_in   = '0;
                  state_in = ST_HOLD;
               end else begin
                  acc_in   = ONE_VALUE;
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            r_in   = prod;
            x_in   = {x_ff[W-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            // end of one modular multiply: pick the next one
            if (cnt_ff == CNT_LAST) begin
               r_in   = '0;
               cnt_in = '0;
               case (op_ff)
                  OP_RED: begin
                     run_in = prod;
                     if (exp_ff[0]) begin
                        op_in = OP_MUL;
                        x_in  = acc_ff;
                        y_in  = prod;
                     end else begin
                        op_in = OP_SQR;
                        x_in  = prod;
                        y_in  = prod;
                     end
                  end
                  OP_MUL: begin
                     acc_in = prod;
                     if (exp_ff[W-1:1] == '0) begin
                        state_in = ST_HOLD;
                     end else begin
                        op_in = OP_SQR;
                        x_in  = run_ff;
                        y_in  = run_ff;
                     end
                  end
                  OP_SQR: begin
                     run_in = prod;
                     exp_in = {1'b0, exp_ff[W-1:1]};
                     if (exp_ff[1]) begin
                        op_in = OP_MUL;
                        x_in  = acc_ff;
                        y_in  = prod;
                     end else begin
                        op_in = OP_SQR;
                        x_in  = prod;
                        y_in  = prod;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_HOLD: begin
            // move the result out once the response register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               out_in       = acc_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      mod_ff <= mod_in;
      exp_ff <= exp_in;
      acc_ff <= acc_in;
      run_ff <= run_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      r_ff   <= r_in;
      out_ff <= out_in;
   end

   // channel outputs
   assign req_ch.ready                = (state_ff == ST_IDLE);
   assign rsp_ch.valid                = rsp_valid_ff;
   assign rsp_ch.payload.power_result = out_ff;

   // checks
   `ASSERT_NEVER(a_run_mod_zero, clock, reset, (state_ff == ST_RUN) && (mod_ff == '0), "multiply with zero modulus")
   `ASSERT_NEVER(a_partial_reduced, clock, reset, (state_ff == ST_RUN) && (r_ff >= mod_ff), "partial product not reduced")
   `ASSERT_NEVER(a_mcand_reduced, clock, reset, (state_ff == ST_RUN) && (y_ff > mod_ff), "multiplicand above modulus")
   `ASSERT_CLK(a_rsp_from_hold, clock, reset, $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_HOLD), "response raised outside hold")

endmodule
